// File: sv/btmg_pkg.sv
// ----------------------------------------------------------------------------
// Battery trimmed mean gauge package
// Shared widths and register indexes for the gauge core and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package btmg_pkg;

   localparam int DIV_W     = 24;
   localparam int DIVISOR_W = 16;
   localparam int DIV_CNT_W = 5;
   localparam int MUL_A_W   = 16;
   localparam int MUL_B_W   = 7;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MV_W      = 20;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_EMPTY_MV    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_MV     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGING_MV = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIVIDER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL0      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL1      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL2      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL3      = 3'd7;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

endpackage

`default_nettype wire

// File: sv/btmg_div.sv
// ----------------------------------------------------------------------------
// Battery gauge restoring divider
// Unsigned shift and subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btmg_div (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  [btmg_pkg::DIV_W-1:0]          dividend,
   input  wire  [btmg_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                done,
   output logic [btmg_pkg::DIV_W-1:0]          quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [btmg_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [btmg_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [btmg_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [btmg_pkg::DIVISOR_W-1:0]     dvs_ff, dvs_in;
   logic [btmg_pkg::DIVISOR_W:0]       shifted;
   logic                               ge;

   assign shifted = {rem_ff, quo_ff[btmg_pkg::DIV_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[btmg_pkg::DIV_W-2:0], ge};
         rem_in = ge ? btmg_pkg::DIVISOR_W'(shifted - {1'b0, dvs_ff})
                     : shifted[btmg_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == btmg_pkg::DIV_CNT_W'(btmg_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a preceding busy cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == '0)
      else $error("divider did not start");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < btmg_pkg::DIV_CNT_W'(btmg_pkg::DIV_W))
      else $error("divider step count out of range");

endmodule

`default_nettype wire

// File: sv/battery_trimmed_mean_gauge_core.sv
// Flow: a non-final sample only updates the burst state; a failed read goes through
// S_ERR to the result register. The last sample of a burst passes S_DIVM, S_WAITM,
// S_MULM, S_MULN, S_MULX and S_PCT, then S_FIN when the percent saturates, else
// S_MULP, S_DIVP and S_WAITP with the 24-step percent divider. One item at a time:
// the next is taken once the sequencer is back in idle, even while the previous
// result still waits. Reset clears the burst state and result valid, loads defaults.
// ----------------------------------------------------------------------------
// Battery trimmed mean gauge core
// Collects a burst of samples, drops the extremes, averages and scales them,
// then maps the result to percent, charging flag and level.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_trimmed_mean_gauge_core #(
   parameter int SAMPLES_PER_BURST = 10,
   parameter int SAMPLE_BITS       = 12
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [SAMPLE_BITS-1:0]               req_sample_mv,
   input  wire                                  req_read_ok,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_status,
   output logic [15:0]                          rsp_battery_mv,
   output logic [15:0]                          rsp_min_mv,
   output logic [15:0]                          rsp_max_mv,
   output logic [6:0]                           rsp_percent,
   output logic                                 rsp_charging,
   output logic [1:0]                           rsp_level,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [btmg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [btmg_pkg::CSR_DAT_W-1:0]       csr_data
);

   localparam int SUM_W = SAMPLE_BITS + 7;
   localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BURST - 1);
   localparam int TRIM_D  = SAMPLES_PER_BURST - 2;
   localparam int RCP_SH  = SUM_W + $clog2(TRIM_D);
   localparam int RCP_W   = SUM_W + 2;
   localparam int RCP_P_W = SUM_W + RCP_W;
   localparam longint RCP_ONE = longint'(1) << RCP_SH;
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'((RCP_ONE + longint'(TRIM_D - 1)) / longint'(TRIM_D));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIVM  = 4'd1;
   localparam logic [3:0] S_WAITM = 4'd2;
   localparam logic [3:0] S_MULM  = 4'd3;
   localparam logic [3:0] S_MULN  = 4'd4;
   localparam logic [3:0] S_MULX  = 4'd5;
   localparam logic [3:0] S_PCT   = 4'd6;
   localparam logic [3:0] S_MULP  = 4'd7;
   localparam logic [3:0] S_DIVP  = 4'd8;
   localparam logic [3:0] S_WAITP = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;
   localparam logic [3:0] S_ERR   = 4'd11;

   logic [15:0]                     empty_ff, empty_in;
   logic [15:0]                     full_ff, full_in;
   logic [15:0]                     chg_ff, chg_in;
   logic [3:0]                      ratio_ff, ratio_in;
   logic [6:0]                      lvl0_ff, lvl0_in;
   logic [6:0]                      lvl1_ff, lvl1_in;
   logic [6:0]                      lvl2_ff, lvl2_in;
   logic [6:0]                      lvl3_ff, lvl3_in;

   logic [3:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]          min_ff, min_in;
   logic [SAMPLE_BITS-1:0]          max_ff, max_in;

   logic [SAMPLE_BITS-1:0]          mean_ff, mean_in;
   logic [btmg_pkg::MV_W-1:0]       mv_ff, mv_in;
   logic [15:0]                     minp_ff, minp_in;
   logic [15:0]                     maxp_ff, maxp_in;
   logic [15:0]                     diff_ff, diff_in;
   logic [btmg_pkg::DIV_W-1:0]      num_ff, num_in;
   logic [6:0]                      pct_ff, pct_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_status_ff, rsp_status_in;
   logic [15:0]                     rsp_mv_ff, rsp_mv_in;
   logic [15:0]                     rsp_min_ff, rsp_min_in;
   logic [15:0]                     rsp_max_ff, rsp_max_in;
   logic [6:0]                      rsp_pct_ff, rsp_pct_in;
   logic                            rsp_chg_ff, rsp_chg_in;
   logic [1:0]                      rsp_lvl_ff, rsp_lvl_in;

   logic                            accept;
   logic                            out_free;
   logic                            csr_we;
   logic [SUM_W-1:0]                trimmed;
   logic [RCP_P_W-1:0]              rcp_p;
   logic [btmg_pkg::MUL_A_W-1:0]    mul_a;
   logic [btmg_pkg::MUL_B_W-1:0]    mul_b;
   logic [btmg_pkg::MUL_P_W-1:0]    mul_p;
   logic                            div_start;
   logic [btmg_pkg::DIV_W-1:0]      div_dividend;
   logic [btmg_pkg::DIVISOR_W-1:0]  div_divisor;
   logic                            div_done;
   logic [btmg_pkg::DIV_W-1:0]      div_quotient;
   logic [1:0]                      level;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign trimmed   = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);

   // The trimmed sum is divided by the count of kept samples, two fewer than the burst,
   // through a rounded-up reciprocal, which is exact for every dividend of SUM_W bits.
   assign rcp_p = RCP_P_W'(num_ff[SUM_W-1:0]) * RCP_P_W'(RCP_MUL);

   always_comb begin
      mul_a = '0;
      mul_b = btmg_pkg::MUL_B_W'(ratio_ff);
      case (state_ff)
         S_MULM:  mul_a = btmg_pkg::MUL_A_W'(mean_ff);
         S_MULN:  mul_a = btmg_pkg::MUL_A_W'(min_ff);
         S_MULX:  mul_a = btmg_pkg::MUL_A_W'(max_ff);
         S_MULP: begin
            mul_a = diff_ff;
            mul_b = btmg_pkg::PCT_FULL;
         end
         default: mul_a = '0;
      endcase
   end

   assign mul_p = btmg_pkg::MUL_P_W'(mul_a) * btmg_pkg::MUL_P_W'(mul_b);

   assign div_start    = state_ff == S_DIVP;
   assign div_dividend = num_ff;
   assign div_divisor  = full_ff - empty_ff;

   btmg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      if (pct_ff < lvl0_ff) begin
         level = 2'd0;
      end else if (pct_ff < lvl1_ff) begin
         level = 2'd1;
      end else if (pct_ff < lvl2_ff) begin
         level = 2'd2;
      end else if (pct_ff < lvl3_ff) begin
         level = 2'd3;
      end else begin
         level = 2'd3;
      end
   end

   always_comb begin
      empty_in = empty_ff;
      full_in  = full_ff;
      chg_in   = chg_ff;
      ratio_in = ratio_ff;
      lvl0_in  = lvl0_ff;
      lvl1_in  = lvl1_ff;
      lvl2_in  = lvl2_ff;
      lvl3_in  = lvl3_ff;
      if (csr_we) begin
         case (csr_index)
            btmg_pkg::REG_EMPTY_MV:    empty_in = csr_data;
            btmg_pkg::REG_FULL_MV:     full_in  = csr_data;
            btmg_pkg::REG_CHARGING_MV: chg_in   = csr_data;
            btmg_pkg::REG_DIVIDER:     ratio_in = csr_data[3:0];
            btmg_pkg::REG_LEVEL0:      lvl0_in  = csr_data[6:0];
            btmg_pkg::REG_LEVEL1:      lvl1_in  = csr_data[6:0];
            btmg_pkg::REG_LEVEL2:      lvl2_in  = csr_data[6:0];
            btmg_pkg::REG_LEVEL3:      lvl3_in  = csr_data[6:0];
            default:                   empty_in = empty_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      mean_in       = mean_ff;
      mv_in         = mv_ff;
      minp_in       = minp_ff;
      maxp_in       = maxp_ff;
      diff_in       = diff_ff;
      num_in        = num_ff;
      pct_in        = pct_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_mv_in     = rsp_mv_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_pct_in    = rsp_pct_ff;
      rsp_chg_in    = rsp_chg_ff;
      rsp_lvl_in    = rsp_lvl_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_read_ok) begin
                  count_in = '0;
                  sum_in   = '0;
                  min_in   = '0;
                  max_in   = '0;
                  state_in = S_ERR;
               end else begin
                  sum_in   = sum_ff + SUM_W'(req_sample_mv);
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0 || req_sample_mv < min_ff) begin
                     min_in = req_sample_mv;
                  end
                  if (count_ff == '0 || req_sample_mv > max_ff) begin
                     max_in = req_sample_mv;
                  end
                  if (count_ff == LAST_CNT) begin
                     state_in = S_DIVM;
                  end
               end
            end
         end
         S_DIVM: begin
            num_in   = btmg_pkg::DIV_W'(trimmed);
            state_in = S_WAITM;
         end
         S_WAITM: begin
            mean_in  = rcp_p[RCP_SH +: SAMPLE_BITS];
            state_in = S_MULM;
         end
         S_MULM: begin
            mv_in    = mul_p[btmg_pkg::MV_W-1:0];
            state_in = S_MULN;
         end
         S_MULN: begin
            minp_in  = mul_p[15:0];
            state_in = S_MULX;
         end
         S_MULX: begin
            maxp_in  = mul_p[15:0];
            state_in = S_PCT;
         end
         S_PCT: begin
            if (mv_ff >= btmg_pkg::MV_W'(full_ff)) begin
               pct_in   = btmg_pkg::PCT_FULL;
               state_in = S_FIN;
            end else if (mv_ff <= btmg_pkg::MV_W'(empty_ff)) begin
               pct_in   = '0;
               state_in = S_FIN;
            end else begin
               diff_in  = mv_ff[15:0] - empty_ff;
               state_in = S_MULP;
            end
         end
         S_MULP: begin
            num_in   = btmg_pkg::DIV_W'(mul_p);
            state_in = S_DIVP;
         end
         S_DIVP: state_in = S_WAITP;
         S_WAITP: begin
            if (div_done) begin
               pct_in   = div_quotient[btmg_pkg::PCT_W-1:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_mv_in     = mv_ff[15:0];
               rsp_min_in    = minp_ff;
               rsp_max_in    = maxp_ff;
               rsp_pct_in    = pct_ff;
               rsp_chg_in    = mv_ff >= btmg_pkg::MV_W'(chg_ff);
               rsp_lvl_in    = level;
               count_in      = '0;
               sum_in        = '0;
               min_in        = '0;
               max_in        = '0;
               state_in      = S_IDLE;
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b1;
               rsp_mv_in     = '0;
               rsp_min_in    = '0;
               rsp_max_in    = '0;
               rsp_pct_in    = '0;
               rsp_chg_in    = 1'b0;
               rsp_lvl_in    = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 16'd3300;
         full_ff      <= 16'd4100;
         chg_ff       <= 16'd4200;
         ratio_ff     <= 4'd2;
         lvl0_ff      <= 7'd20;
         lvl1_ff      <= 7'd50;
         lvl2_ff      <= 7'd80;
         lvl3_ff      <= 7'd100;
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         empty_ff     <= empty_in;
         full_ff      <= full_in;
         chg_ff       <= chg_in;
         ratio_ff     <= ratio_in;
         lvl0_ff      <= lvl0_in;
         lvl1_ff      <= lvl1_in;
         lvl2_ff      <= lvl2_in;
         lvl3_ff      <= lvl3_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff       <= mean_in;
      mv_ff         <= mv_in;
      minp_ff       <= minp_in;
      maxp_ff       <= maxp_in;
      diff_ff       <= diff_in;
      num_ff        <= num_in;
      pct_ff        <= pct_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_chg_ff    <= rsp_chg_in;
      rsp_lvl_ff    <= rsp_lvl_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_battery_mv = rsp_mv_ff;
   assign rsp_min_mv     = rsp_min_ff;
   assign rsp_max_mv     = rsp_max_ff;
   assign rsp_percent    = rsp_pct_ff;
   assign rsp_charging   = rsp_chg_ff;
   assign rsp_level      = rsp_lvl_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SAMPLES_PER_BURST))
      else $error("burst sample count out of range");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_WAITM || state_ff == S_WAITP)
      else $error("divider finished outside a wait state");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ERR && out_free |=>
         rsp_valid_ff && rsp_status_ff && count_ff == '0 && sum_ff == '0)
      else $error("aborted burst not reported or not cleared");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_status_ff |-> rsp_pct_ff <= btmg_pkg::PCT_FULL)
      else $error("percent above full scale");

endmodule

`default_nettype wire

// File: bench/tb_battery_trimmed_mean_gauge_core.sv
// ----------------------------------------------------------------------------
// Testbench for the battery trimmed mean gauge core
// Sends samples and failed reads through the sample channel. A directed table
// comes first. Random bursts follow under several register setups and idling
// patterns. Each reading that comes back is compared with a pinned reading from the
// table or with a software gauge that tracks the burst and registers alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_battery_trimmed_mean_gauge_core;

   localparam int SAMPLE_W       = 12;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
   localparam int BURST_LEN      = 10;
   localparam int DIR_N          = 25;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_SET  = 160;
   localparam int SETTLE_CYCLES  = 80;
   localparam int STUCK_LIMIT    = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic        status;
      logic [15:0] battery_mv;
      logic [15:0] min_mv;
      logic [15:0] max_mv;
      logic [6:0]  percent;
      logic        charging;
      logic [1:0]  level;
   } gauge_reading_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                ok;
      logic                pinned;
      gauge_reading_type   want;
   } stim_row_type;

   localparam gauge_reading_type NO_READING = '0;
   localparam gauge_reading_type ABORTED    =
      '{1'b1, 16'd0, 16'd0, 16'd0, 7'd0, 1'b0, 2'd0};
   localparam gauge_reading_type ALL_HIGH   =
      '{1'b0, 16'd8190, 16'd8190, 16'd8190, 7'd100, 1'b1, 2'd3};
   localparam gauge_reading_type ALL_ZERO   =
      '{1'b0, 16'd0, 16'd0, 16'd0, 7'd0, 1'b0, 2'd0};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_sample_mv;
   logic                 req_read_ok;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_status;
   logic [15:0]          rsp_battery_mv;
   logic [15:0]          rsp_min_mv;
   logic [15:0]          rsp_max_mv;
   logic [6:0]           rsp_percent;
   logic                 rsp_charging;
   logic [1:0]           rsp_level;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [btmg_pkg::CSR_IDX_W-1:0] csr_index;
   logic [btmg_pkg::CSR_DAT_W-1:0] csr_data;

   logic [15:0]          cfg_empty;
   logic [15:0]          cfg_full;
   logic [15:0]          cfg_charging;
   logic [3:0]           cfg_ratio;
   logic [6:0]           cfg_level [4];

   logic [6:0]           burst_cnt;
   logic [17:0]          burst_sum;
   logic [SAMPLE_W-1:0]  burst_lo;
   logic [SAMPLE_W-1:0]  burst_hi;

   gauge_reading_type    pending_readings [$];
   gauge_reading_type    got;
   gauge_reading_type    want;

   int                   send_gap_pct  = 0;
   int                   rsp_stall_pct = 0;
   int                   samples_sent  = 0;
   int                   readings_checked = 0;
   int                   reg_writes    = 0;
   int                   mismatch_count = 0;
   int                   stuck_cycles;

   wire any_accept = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                     (csr_valid && csr_ready);

   stim_row_type directed_rows [DIR_N] = '{
      '{12'd0,    1'b0, 1'b1, ABORTED},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b1, 1'b1, ALL_HIGH},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b0, NO_READING},
      '{12'd0,    1'b1, 1'b1, ALL_ZERO},
      '{12'd2000, 1'b1, 1'b0, NO_READING},
      '{12'd1900, 1'b1, 1'b0, NO_READING},
      '{12'd2100, 1'b1, 1'b0, NO_READING},
      '{12'd4095, 1'b0, 1'b1, ABORTED}
   };

   battery_trimmed_mean_gauge_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_mv  (req_sample_mv),
      .req_read_ok    (req_read_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_battery_mv (rsp_battery_mv),
      .rsp_min_mv     (rsp_min_mv),
      .rsp_max_mv     (rsp_max_mv),
      .rsp_percent    (rsp_percent),
      .rsp_charging   (rsp_charging),
      .rsp_level      (rsp_level),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit predict_reading(input logic [SAMPLE_W-1:0] s, input logic ok,
                                          output gauge_reading_type r);
      logic [31:0] mean;
      logic [31:0] mv;
      logic [31:0] pct;
      r = '0;
      if (!ok) begin
         burst_cnt = '0;
         burst_sum = '0;
         burst_lo  = '0;
         burst_hi  = '0;
         r.status  = 1'b1;
         return 1'b1;
      end
      burst_sum = burst_sum + 18'(s);
      if (burst_cnt == 0) begin
         burst_lo = s;
         burst_hi = s;
      end else begin
         if (s < burst_lo) burst_lo = s;
         if (s > burst_hi) burst_hi = s;
      end
      burst_cnt = burst_cnt + 1'b1;
      if (burst_cnt < BURST_LEN) return 1'b0;
      mean = (32'(burst_sum) - 32'(burst_lo) - 32'(burst_hi)) / (BURST_LEN - 2);
      mv   = mean * 32'(cfg_ratio);
      if (mv >= 32'(cfg_full)) begin
         pct = 100;
      end else if (mv <= 32'(cfg_empty)) begin
         pct = 0;
      end else begin
         pct = ((mv - 32'(cfg_empty)) * 100) / (32'(cfg_full) - 32'(cfg_empty));
      end
      r.battery_mv = mv[15:0];
      r.min_mv     = 16'(32'(burst_lo) * 32'(cfg_ratio));
      r.max_mv     = 16'(32'(burst_hi) * 32'(cfg_ratio));
      r.percent    = pct[6:0];
      r.charging   = (mv >= 32'(cfg_charging));
      r.level      = 2'd3;
      for (int i = 3; i >= 0; i--) begin
         if (pct < 32'(cfg_level[i])) r.level = 2'(i);
      end
      burst_cnt = '0;
      burst_sum = '0;
      burst_lo  = '0;
      burst_hi  = '0;
      return 1'b1;
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic ok,
                              input logic pinned, input gauge_reading_type pinned_reading);
      gauge_reading_type r;
      bit                has_reading;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_mv <= s;
      req_read_ok   <= ok;
      do @(posedge clock); while (req_stall !== 1'b0);
      has_reading = predict_reading(s, ok, r);
      if (pinned) begin
         pending_readings.push_back(pinned_reading);
      end else if (has_reading) begin
         pending_readings.push_back(r);
      end
      samples_sent++;
   endtask

   task automatic write_reg(input logic [btmg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         btmg_pkg::REG_EMPTY_MV:    cfg_empty    = val;
         btmg_pkg::REG_FULL_MV:     cfg_full     = val;
         btmg_pkg::REG_CHARGING_MV: cfg_charging = val;
         btmg_pkg::REG_DIVIDER:     cfg_ratio    = val[3:0];
         btmg_pkg::REG_LEVEL0:      cfg_level[0] = val[6:0];
         btmg_pkg::REG_LEVEL1:      cfg_level[1] = val[6:0];
         btmg_pkg::REG_LEVEL2:      cfg_level[2] = val[6:0];
         btmg_pkg::REG_LEVEL3:      cfg_level[3] = val[6:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic program_gauge(input int empty_val, input int full_val, input int charge_val,
                                input int ratio_val, input int lvl0, input int lvl1,
                                input int lvl2, input int lvl3);
      write_reg(btmg_pkg::REG_EMPTY_MV,    16'(empty_val));
      write_reg(btmg_pkg::REG_FULL_MV,     16'(full_val));
      write_reg(btmg_pkg::REG_CHARGING_MV, 16'(charge_val));
      write_reg(btmg_pkg::REG_DIVIDER,     16'(ratio_val));
      write_reg(btmg_pkg::REG_LEVEL0,      16'(lvl0));
      write_reg(btmg_pkg::REG_LEVEL1,      16'(lvl1));
      write_reg(btmg_pkg::REG_LEVEL2,      16'(lvl2));
      write_reg(btmg_pkg::REG_LEVEL3,      16'(lvl3));
      csr_valid <= 1'b0;
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_samples(input int count);
      int   style;
      int   center;
      int   spread;
      int   target;
      int   s;
      logic ok;
      center = 0;
      spread = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_cnt == 0) begin
            style = $urandom_range(99);
            if (style < 30) begin
               center = $urandom_range(SAMPLE_MAX);
               spread = SAMPLE_MAX;
            end else if (style < 70) begin
               case ($urandom_range(3))
                  0: target = int'(cfg_empty);
                  1: target = int'(cfg_full);
                  2: target = int'(cfg_charging);
                  default: target = int'($urandom_range(cfg_empty, cfg_full));
               endcase
               target = target + int'($urandom_range(128)) - 64;
               center = (cfg_ratio == 0) ? int'($urandom_range(SAMPLE_MAX))
                                         : target / int'(cfg_ratio);
               spread = $urandom_range(8);
            end else if (style < 85) begin
               center = $urandom_range(SAMPLE_MAX);
               spread = 0;
            end else begin
               center = $urandom_range(1) ? SAMPLE_MAX : 0;
               spread = $urandom_range(3);
            end
         end
         s = center + int'($urandom_range(2 * spread)) - spread;
         if ($urandom_range(99) < 5) s = $urandom_range(SAMPLE_MAX);
         if (s < 0) s = 0;
         else if (s > SAMPLE_MAX) s = SAMPLE_MAX;
         ok = ($urandom_range(99) >= 2);
         send_sample(s[SAMPLE_W-1:0], ok, 1'b0, NO_READING);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_status, rsp_battery_mv, rsp_min_mv, rsp_max_mv,
                 rsp_percent, rsp_charging, rsp_level};
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: reading with none pending: st=%0d mv=%0d min=%0d max=%0d",
                        $time, got.status, got.battery_mv, got.min_mv, got.max_mv);
            end
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch, want st=%0d mv=%0d min=%0d max=%0d pct=%0d chg=%0d lvl=%0d",
                           $time, want.status, want.battery_mv, want.min_mv, want.max_mv,
                           want.percent, want.charging, want.level);
                  $display("%0t:             got st=%0d mv=%0d min=%0d max=%0d pct=%0d chg=%0d lvl=%0d",
                           $time, got.status, got.battery_mv, got.min_mv, got.max_mv,
                           got.percent, got.charging, got.level);
               end
            end
         end
      end
   end

   initial begin
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (any_accept === 1'b1) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles.", STUCK_LIMIT);
      $display("** battery_trimmed_mean_gauge_core: FAILED **");
      $finish;
   end

   initial begin
      int set_empty;
      int set_full;
      int set_charge;
      int set_ratio;
      int set_lvl [4];
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_mv <= '0;
      req_read_ok   <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= btmg_pkg::REG_EMPTY_MV;
      csr_data      <= '0;
      cfg_empty     = 16'd3300;
      cfg_full      = 16'd4100;
      cfg_charging  = 16'd4200;
      cfg_ratio     = 4'd2;
      cfg_level     = '{7'd20, 7'd50, 7'd80, 7'd100};
      burst_cnt     = '0;
      burst_sum     = '0;
      burst_lo      = '0;
      burst_hi      = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) begin
         send_sample(directed_rows[i].sample, directed_rows[i].ok,
                     directed_rows[i].pinned, directed_rows[i].want);
      end

      for (int phase = 1; phase <= PHASES; phase++) begin
         drain_readings();
         case (idle_mode_type'(phase % 4))
            IDLE_NONE:     begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 84; rsp_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  rsp_stall_pct = 84; end
            default:       begin send_gap_pct = 21; rsp_stall_pct = 21; end
         endcase
         set_ratio  = (phase == 6) ? 1 : (phase == 8) ? 8 : int'($urandom_range(1, 8));
         set_empty  = $urandom_range(SAMPLE_MAX * set_ratio - 1);
         set_full   = set_empty + int'($urandom_range(2, 3000));
         if (set_full > 65535) set_full = 65535;
         set_charge = $urandom_range(set_empty, set_full + 600);
         set_lvl[0] = $urandom_range(40);
         set_lvl[1] = set_lvl[0] + int'($urandom_range(30));
         set_lvl[2] = set_lvl[1] + int'($urandom_range(30));
         set_lvl[3] = $urandom_range(set_lvl[2], (phase == 8) ? 127 : 100);
         case (phase)
            1: begin
               set_empty  = 3300;
               set_full   = 4100;
               set_charge = 4200;
               set_ratio  = 2;
               set_lvl    = '{20, 50, 80, 100};
            end
            3: begin
               set_empty  = 0;
               set_full   = 0;
               set_charge = 0;
               set_ratio  = 0;
               set_lvl    = '{0, 0, 0, 0};
            end
            4: begin
               set_empty  = 65535;
               set_full   = 65535;
               set_charge = 65535;
               set_ratio  = 15;
               set_lvl    = '{127, 127, 127, 127};
            end
            5: begin
               set_full  = $urandom_range(1000, 6000);
               set_empty = set_full + int'($urandom_range(2000));
            end
            7: begin
               set_empty  = $urandom_range(65535);
               set_full   = $urandom_range(65535);
               set_charge = $urandom_range(65535);
               set_ratio  = $urandom_range(65535);
               for (int i = 0; i < 4; i++) set_lvl[i] = $urandom_range(65535);
            end
            default: ;
         endcase
         program_gauge(set_empty, set_full, set_charge, set_ratio,
                       set_lvl[0], set_lvl[1], set_lvl[2], set_lvl[3]);
         random_samples(ITEMS_PER_SET);
      end

      drain_readings();
      if (pending_readings.size() != 0) begin
         $display("%0d readings never arrived.", pending_readings.size());
         mismatch_count += pending_readings.size();
      end
      $display("Sent %0d samples and checked %0d readings over %0d register writes,",
               samples_sent, readings_checked, reg_writes);
      $display("covering default, extreme, inverted and random setups; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("** battery_trimmed_mean_gauge_core: PASSED **");
      end else begin
         $display("** battery_trimmed_mean_gauge_core: FAILED **");
      end
      $finish;
   end

endmodule
